// File: sv/jacobi_helmholtz_smoother_1d_defines.svh
// assertion macros shared by the smoother rtl
`ifndef JACOBI_HELMHOLTZ_SMOOTHER_1D_DEFINES_SVH
`define JACOBI_HELMHOLTZ_SMOOTHER_1D_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property checked on every clock edge outside reset
`define JHS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication checked on every clock edge outside reset
`define JHS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define JHS_ASSERT(label, prop, msg)
`define JHS_ASSERT_IMPL(label, ante, cons, msg)

`endif

`endif

// File: sv/jhs_pkg.sv
`default_nettype none

package jhs_pkg;

    // grid geometry
    localparam int GRID_POINTS  = 64;
    localparam int GUARD_POINTS = 2;

    // field widths
    localparam int VAL_W     = 32;
    localparam int FLOOR_W   = 16;
    localparam int SWEEP_W   = 10;
    localparam int CFG_IDX_W = 3;

    // counters
    localparam int CNT_W     = $clog2(GRID_POINTS + 1);
    localparam int UPD_DEPTH = 10;
    localparam int LOOP_LEN  = GRID_POINTS + UPD_DEPTH;
    localparam int LOOP_W    = $clog2(LOOP_LEN);
    localparam int HEAD_W    = LOOP_W + 1;

    // datapath widths
    localparam int MAG_W  = 63;
    localparam int SAT_W  = 51;
    localparam int SUM_W  = 33;
    localparam int TERM_W = 49;
    localparam int NUM_W  = 50;
    localparam int NHI_W  = NUM_W - VAL_W;
    localparam int MIX_W  = 35;
    localparam int Y_W    = 33;
    localparam int Q5_W   = 31;

    // divide by five: x = hi*2^32 + lo, 2^32 = 5*DIV5_BASE + 1
    localparam logic [VAL_W-1:0] DIV5_BASE   = 32'd858993459;
    localparam logic [33:0]      DIV5_MUL    = 34'h3_3333_3334;
    localparam int               DIV5_SHIFT  = 36;
    localparam int               DIV5_PROD_W = Y_W + 34;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUPLING    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DENOM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEPS      = 3'd4;

    // register reset values
    localparam logic [VAL_W-1:0]   GAIN_RST   = 32'd655360;
    localparam logic [VAL_W-1:0]   COUP_RST   = 32'd65536;
    localparam logic [VAL_W-1:0]   INV_RST    = 32'd1431655765;
    localparam logic [FLOOR_W-1:0] FLOOR_RST  = 16'd1;
    localparam logic [SWEEP_W-1:0] SWEEPS_RST = 10'd100;

    typedef enum logic [1:0] {
        PH_LOAD,
        PH_PAD,
        PH_SWEEP,
        PH_EMIT
    } t_phase;

    typedef struct packed {
        logic [VAL_W-1:0] field;
        logic [VAL_W-1:0] rhs;
    } t_point;

    typedef struct packed {
        t_point pt;
        logic   inner;
    } t_stage;

    typedef struct packed {
        logic [VAL_W-1:0]   coupling;
        logic [VAL_W-1:0]   inv_denom;
        logic [FLOOR_W-1:0] floor_value;
    } t_upd_cfg;

    // saturate to 32 bits, then lift to the floor
    function automatic logic [VAL_W-1:0] sat_floor(input logic [SAT_W-1:0]   v,
                                                   input logic [FLOOR_W-1:0] fl);
        logic [VAL_W-1:0] res;
        res = (|v[SAT_W-1:VAL_W]) ? '1 : v[VAL_W-1:0];
        if (res < VAL_W'(fl)) begin
            res = VAL_W'(fl);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: sv/jhs_src_if.sv
`default_nettype none

interface jhs_src_if;
    logic                            valid;
    logic                            ready;
    logic signed [jhs_pkg::VAL_W-1:0] source_value;
    logic                            last_point;

    modport source (output valid, output source_value, output last_point, input ready);
    modport sink   (input valid, input source_value, input last_point, output ready);
endinterface

`default_nettype wire

// File: sv/jhs_res_if.sv
`default_nettype none

interface jhs_res_if;
    logic                      valid;
    logic                      ready;
    logic [jhs_pkg::VAL_W-1:0] smoothed_value;
    logic                      last_value;

    modport source (output valid, output smoothed_value, output last_value, input ready);
    modport sink   (input valid, input smoothed_value, input last_value, output ready);
endinterface

`default_nettype wire

// File: sv/jacobi_helmholtz_smoother_1d.sv
`default_nettype none

// damped jacobi smoother, 1d three-point stencil, unsigned q16.16 field
// source items stream in one per cycle; each is scaled by source_gain, clamped
// to floor_value and stored as both rhs and starting field in a row of 64
// cells. up to 64 points are kept, later ones are dropped; last_point starts
// the solve. the cells form a ring with a 10-stage update pipeline, and one
// sweep passes the whole ring (64 cells plus the pipeline) through the update,
// no matter how many points were loaded. a solve runs the points through the
// scaling registers, shifts filler in to align the row, runs sweep_count sweeps
// (skipped for grids under five points or zero sweeps), then sends n result
// items, one per cycle while the sink is ready. input is held off from the last
// point until the last result item has been taken into the output register.
// guard points at both ends pass through the pipeline unchanged
`include "jacobi_helmholtz_smoother_1d_defines.svh"

module jacobi_helmholtz_smoother_1d (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    jhs_src_if.sink                           i_src,
    jhs_res_if.source                         o_res,
    input  logic                              i_cfg_we,
    input  logic [jhs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [jhs_pkg::VAL_W-1:0]         i_cfg_data
);

    // configuration registers
    logic [jhs_pkg::VAL_W-1:0]   r_gain;
    logic [jhs_pkg::VAL_W-1:0]   r_coup;
    logic [jhs_pkg::VAL_W-1:0]   r_inv;
    logic [jhs_pkg::FLOOR_W-1:0] r_floor;
    logic [jhs_pkg::SWEEP_W-1:0] r_sweeps;

    // control
    jhs_pkg::t_phase             r_state, n_state;
    logic [jhs_pkg::CNT_W-1:0]   r_count, n_count;
    logic [jhs_pkg::CNT_W-1:0]   r_fill, n_fill;
    logic [jhs_pkg::CNT_W-1:0]   r_emit, n_emit;
    logic [jhs_pkg::LOOP_W-1:0]  r_loop, n_loop;
    logic [jhs_pkg::SWEEP_W-1:0] r_sweep, n_sweep;

    // input scaling pipe
    logic                        r_p1_vld;
    logic [jhs_pkg::VAL_W-1:0]   r_p1_val;
    logic                        r_p2_vld;
    logic [jhs_pkg::MAG_W-1:0]   r_p2_mag;

    // output register
    logic                        r_out_vld;
    logic [jhs_pkg::VAL_W-1:0]   r_out_val;
    logic                        r_out_last;

    logic w_ready, w_accept, w_room;
    logic w_load_shift, w_pad_shift, w_sweep_en, w_emit_shift, w_chain_shift;
    logic w_pipe_empty, w_fill_done, w_can_sweep;
    logic w_loop_end, w_sweep_end, w_emit_end, w_head_inner;

    logic [jhs_pkg::MAG_W-1:0] w_mag;
    logic [jhs_pkg::VAL_W-1:0] w_scaled;
    jhs_pkg::t_point           w_load_pt, w_tail, w_chain_in;
    jhs_pkg::t_point           w_cell [jhs_pkg::GRID_POINTS];
    jhs_pkg::t_upd_cfg         w_upd_cfg;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= jhs_pkg::GAIN_RST;
            r_coup   <= jhs_pkg::COUP_RST;
            r_inv    <= jhs_pkg::INV_RST;
            r_floor  <= jhs_pkg::FLOOR_RST;
            r_sweeps <= jhs_pkg::SWEEPS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                jhs_pkg::CFG_SOURCE_GAIN: r_gain   <= i_cfg_data;
                jhs_pkg::CFG_COUPLING:    r_coup   <= i_cfg_data;
                jhs_pkg::CFG_INV_DENOM:   r_inv    <= i_cfg_data;
                jhs_pkg::CFG_FLOOR:       r_floor  <= i_cfg_data[jhs_pkg::FLOOR_W-1:0];
                jhs_pkg::CFG_SWEEPS:      r_sweeps <= i_cfg_data[jhs_pkg::SWEEP_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input side: accept, gain multiply, saturate and floor
    // ------------------------------------------------------------------
    assign w_accept = i_src.valid && w_ready;
    assign w_room   = r_count < jhs_pkg::CNT_W'(jhs_pkg::GRID_POINTS);

    // negative samples give zero, which the floor lifts
    assign w_mag = r_p1_val[jhs_pkg::VAL_W-1] ? '0
                 : jhs_pkg::MAG_W'(r_p1_val[jhs_pkg::VAL_W-2:0]) * jhs_pkg::MAG_W'(r_gain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            r_p1_vld <= w_accept && w_room;
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_val <= i_src.source_value;
        r_p2_mag <= w_mag;
    end

    assign w_scaled  = jhs_pkg::sat_floor(jhs_pkg::SAT_W'(r_p2_mag[jhs_pkg::MAG_W-1:16]),
                                          r_floor);
    assign w_load_pt = '{field: w_scaled, rhs: w_scaled};

    // ------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------
    assign w_pipe_empty = !r_p1_vld && !r_p2_vld;
    assign w_fill_done  = r_fill == jhs_pkg::CNT_W'(jhs_pkg::GRID_POINTS);
    assign w_can_sweep  = (r_count >= jhs_pkg::CNT_W'(2 * jhs_pkg::GUARD_POINTS + 1))
                       && (r_sweeps != '0);
    assign w_loop_end   = r_loop == jhs_pkg::LOOP_W'(jhs_pkg::LOOP_LEN - 1);
    assign w_sweep_end  = w_loop_end && (r_sweep == r_sweeps - jhs_pkg::SWEEP_W'(1));
    assign w_emit_end   = r_emit == r_count - jhs_pkg::CNT_W'(1);
    assign w_load_shift = r_p2_vld;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            jhs_pkg::PH_LOAD: begin
                if (w_accept && i_src.last_point) begin
                    n_state = jhs_pkg::PH_PAD;
                end
            end
            jhs_pkg::PH_PAD: begin
                if (w_pipe_empty && w_fill_done) begin
                    n_state = w_can_sweep ? jhs_pkg::PH_SWEEP : jhs_pkg::PH_EMIT;
                end
            end
            jhs_pkg::PH_SWEEP: begin
                if (w_sweep_end) begin
                    n_state = jhs_pkg::PH_EMIT;
                end
            end
            jhs_pkg::PH_EMIT: begin
                if (w_emit_shift && w_emit_end) begin
                    n_state = jhs_pkg::PH_LOAD;
                end
            end
            default: n_state = jhs_pkg::PH_LOAD;
        endcase
    end

    // state outputs
    always_comb begin
        w_ready      = 1'b0;
        w_pad_shift  = 1'b0;
        w_sweep_en   = 1'b0;
        w_emit_shift = 1'b0;
        case (r_state)
            jhs_pkg::PH_LOAD:  w_ready      = 1'b1;
            // shift filler in until point 0 sits in the head cell
            jhs_pkg::PH_PAD:   w_pad_shift  = w_pipe_empty && !w_fill_done;
            jhs_pkg::PH_SWEEP: w_sweep_en   = 1'b1;
            jhs_pkg::PH_EMIT:  w_emit_shift = !r_out_vld || o_res.ready;
            default: ;
        endcase
    end

    assign i_src.ready = w_ready;

    // counters
    always_comb begin
        n_count = r_count;
        n_fill  = r_fill;
        n_emit  = r_emit;
        n_loop  = '0;
        n_sweep = '0;
        if (w_accept && w_room) begin
            n_count = r_count + jhs_pkg::CNT_W'(1);
        end
        if (w_load_shift || w_pad_shift) begin
            n_fill = r_fill + jhs_pkg::CNT_W'(1);
        end
        if (w_sweep_en) begin
            n_loop  = w_loop_end ? '0 : r_loop + jhs_pkg::LOOP_W'(1);
            n_sweep = r_sweep;
            if (w_loop_end) begin
                n_sweep = w_sweep_end ? '0 : r_sweep + jhs_pkg::SWEEP_W'(1);
            end
        end
        if (w_emit_shift) begin
            n_emit = r_emit + jhs_pkg::CNT_W'(1);
            if (w_emit_end) begin
                n_emit  = '0;
                n_count = '0;
                n_fill  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jhs_pkg::PH_LOAD;
            r_count <= '0;
            r_fill  <= '0;
            r_emit  <= '0;
            r_loop  <= '0;
            r_sweep <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_fill  <= n_fill;
            r_emit  <= n_emit;
            r_loop  <= n_loop;
            r_sweep <= n_sweep;
        end
    end

    // ------------------------------------------------------------------
    // ring: cell row plus update pipeline
    // ------------------------------------------------------------------
    // slot r_loop is at the head; interior when guard <= idx < n - guard
    assign w_head_inner = (r_loop >= jhs_pkg::LOOP_W'(jhs_pkg::GUARD_POINTS))
                       && ((jhs_pkg::HEAD_W'(r_loop) + jhs_pkg::HEAD_W'(jhs_pkg::GUARD_POINTS))
                           < jhs_pkg::HEAD_W'(r_count));

    assign w_chain_shift = w_load_shift || w_pad_shift || w_sweep_en || w_emit_shift;
    assign w_chain_in    = w_sweep_en ? w_tail : w_load_pt;

    for (genvar g = 0; g < jhs_pkg::GRID_POINTS; g++) begin : g_cell
        if (g == jhs_pkg::GRID_POINTS - 1) begin : g_tail
            jhs_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_chain_shift),
                .i_pt    (w_chain_in),
                .o_pt    (w_cell[g])
            );
        end else begin : g_body
            jhs_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_chain_shift),
                .i_pt    (w_cell[g+1]),
                .o_pt    (w_cell[g])
            );
        end
    end

    assign w_upd_cfg = '{coupling: r_coup, inv_denom: r_inv, floor_value: r_floor};

    jhs_update u_update (
        .i_clk        (i_clk),
        .i_en         (w_sweep_en),
        .i_cfg        (w_upd_cfg),
        .i_head       (w_cell[0]),
        .i_head_inner (w_head_inner),
        .o_tail       (w_tail)
    );

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_emit_shift) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_shift) begin
            r_out_val  <= jhs_pkg::sat_floor(jhs_pkg::SAT_W'(w_cell[0].field), r_floor);
            r_out_last <= w_emit_end;
        end
    end

    assign o_res.valid          = r_out_vld;
    assign o_res.smoothed_value = r_out_val;
    assign o_res.last_value     = r_out_last;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `JHS_ASSERT(a_count_range, (r_count <= jhs_pkg::CNT_W'(jhs_pkg::GRID_POINTS)) && (r_fill <= jhs_pkg::CNT_W'(jhs_pkg::GRID_POINTS)), "point or fill count beyond grid")
    `JHS_ASSERT_IMPL(a_pad_aligned, (r_state == jhs_pkg::PH_PAD) && (n_state != jhs_pkg::PH_PAD), w_fill_done && w_pipe_empty, "solve started before row aligned")
    `JHS_ASSERT_IMPL(a_sweep_whole, (r_state == jhs_pkg::PH_SWEEP) && (n_state != jhs_pkg::PH_SWEEP), w_loop_end, "sweeps left ring misaligned")

endmodule

`default_nettype wire

// File: sv/jhs_cell.sv
`default_nettype none

// one grid slot: field and rhs, shifted toward the head
module jhs_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  jhs_pkg::t_point i_pt,
    output jhs_pkg::t_point o_pt
);

    jhs_pkg::t_point r_pt;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_pt <= i_pt;
        end
    end

    assign o_pt = r_pt;

endmodule

`default_nettype wire

// File: sv/jhs_update.sv
`default_nettype none

// pipelined three-point update, one point per cycle while i_en is high
module jhs_update (
    input  logic              i_clk,
    input  logic              i_en,
    input  jhs_pkg::t_upd_cfg i_cfg,
    input  jhs_pkg::t_point   i_head,
    input  logic              i_head_inner,
    output jhs_pkg::t_point   o_tail
);

    jhs_pkg::t_stage r_s1, r_c1, r_c2, r_c3, r_c4, r_c5, r_c6, r_c7, r_c8, r_c9;

    logic [jhs_pkg::VAL_W-1:0]  r_left;
    logic [jhs_pkg::SUM_W-1:0]  r_c1_sum;
    logic [jhs_pkg::TERM_W-1:0] r_c2_term;
    logic [jhs_pkg::NUM_W-1:0]  r_c3_num;
    logic [2*jhs_pkg::VAL_W-1:0] r_c4_plo;
    logic [jhs_pkg::NHI_W-1:0]  r_c4_nhi;
    logic [jhs_pkg::NUM_W-1:0]  r_c5_phi;
    logic [jhs_pkg::VAL_W-1:0]  r_c5_plh;
    logic [jhs_pkg::VAL_W-1:0]  r_c6_new;
    logic [jhs_pkg::MIX_W-1:0]  r_c7_mix;
    logic [jhs_pkg::Y_W-1:0]    r_c8_y;
    logic [jhs_pkg::VAL_W-1:0]  r_c8_base;
    logic [jhs_pkg::Q5_W-1:0]   r_c9_q;
    logic [jhs_pkg::VAL_W-1:0]  r_c9_base;

    logic [jhs_pkg::SUM_W+jhs_pkg::VAL_W-1:0] w_coup_prod;
    logic [2*jhs_pkg::VAL_W-1:0]              w_plo;
    logic [jhs_pkg::NUM_W-1:0]                w_phi;
    logic [jhs_pkg::MIX_W-1:0]                w_base;
    logic [jhs_pkg::DIV5_PROD_W-1:0]          w_q5;

    assign w_coup_prod = (jhs_pkg::SUM_W+jhs_pkg::VAL_W)'(r_c1_sum)
                       * (jhs_pkg::SUM_W+jhs_pkg::VAL_W)'(i_cfg.coupling);
    assign w_plo = (2*jhs_pkg::VAL_W)'(r_c3_num[jhs_pkg::VAL_W-1:0])
                 * (2*jhs_pkg::VAL_W)'(i_cfg.inv_denom);
    assign w_phi = jhs_pkg::NUM_W'(r_c4_nhi) * jhs_pkg::NUM_W'(i_cfg.inv_denom);
    assign w_base = jhs_pkg::MIX_W'(r_c7_mix[jhs_pkg::MIX_W-1:jhs_pkg::VAL_W])
                  * jhs_pkg::MIX_W'(jhs_pkg::DIV5_BASE);
    assign w_q5 = jhs_pkg::DIV5_PROD_W'(r_c8_y) * jhs_pkg::DIV5_PROD_W'(jhs_pkg::DIV5_MUL);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // window: left, center in s1, right at the head
            r_s1     <= '{pt: i_head, inner: i_head_inner};
            r_left   <= r_s1.pt.field;
            r_c1     <= r_s1;
            r_c1_sum <= jhs_pkg::SUM_W'(r_left) + jhs_pkg::SUM_W'(i_head.field);
            // coupling term, Q16.16
            r_c2      <= r_c1;
            r_c2_term <= w_coup_prod[jhs_pkg::SUM_W+jhs_pkg::VAL_W-1:16];
            r_c3      <= r_c2;
            r_c3_num  <= jhs_pkg::NUM_W'(r_c2.pt.rhs) + jhs_pkg::NUM_W'(r_c2_term);
            // numerator times reciprocal, split in two partial products
            r_c4      <= r_c3;
            r_c4_plo  <= w_plo;
            r_c4_nhi  <= r_c3_num[jhs_pkg::NUM_W-1:jhs_pkg::VAL_W];
            r_c5      <= r_c4;
            r_c5_phi  <= w_phi;
            r_c5_plh  <= r_c4_plo[2*jhs_pkg::VAL_W-1:jhs_pkg::VAL_W];
            r_c6      <= r_c5;
            r_c6_new  <= jhs_pkg::sat_floor(jhs_pkg::SAT_W'(r_c5_phi)
                                            + jhs_pkg::SAT_W'(r_c5_plh),
                                            i_cfg.floor_value);
            // relaxation (4*new + old) / 5
            r_c7      <= r_c6;
            r_c7_mix  <= jhs_pkg::MIX_W'({r_c6_new, 2'b00})
                       + jhs_pkg::MIX_W'(r_c6.pt.field);
            r_c8      <= r_c7;
            r_c8_y    <= jhs_pkg::Y_W'(r_c7_mix[jhs_pkg::VAL_W-1:0])
                       + jhs_pkg::Y_W'(r_c7_mix[jhs_pkg::MIX_W-1:jhs_pkg::VAL_W]);
            r_c8_base <= w_base[jhs_pkg::VAL_W-1:0];
            r_c9      <= r_c8;
            r_c9_q    <= w_q5[jhs_pkg::DIV5_PROD_W-1:jhs_pkg::DIV5_SHIFT];
            r_c9_base <= r_c8_base;
        end
    end

    always_comb begin
        o_tail.rhs   = r_c9.pt.rhs;
        o_tail.field = r_c9.inner ? r_c9_base + jhs_pkg::VAL_W'(r_c9_q) : r_c9.pt.field;
    end

endmodule

`default_nettype wire

// File: bench/jacobi_helmholtz_smoother_1d_test.sv
`default_nettype none

module jacobi_helmholtz_smoother_1d_test;
    timeunit 1ns;
    timeprecision 1ps;

    import jhs_pkg::*;

    // run shape
    localparam int CYCLE_LIMIT   = 3_000_000; // well above the slowest legal run
    localparam int SETTLE_CYCLES = 16;        // margin over the load pipeline
    localparam int TAIL_CYCLES   = 100;
    localparam int RANDOM_ITEMS  = 280;
    localparam int MAX_REPORTS   = 10;
    localparam int BLOCK_STALL   = 400;       // long hold-off on the result side

    // one solved grid point as it leaves the block
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
    } t_field_sample;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [VAL_W-1:0]     cfg_data  = '0;

    jhs_src_if src_ch ();
    jhs_res_if res_ch ();

    jacobi_helmholtz_smoother_1d DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_src       (src_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    int unsigned cycle_count = 0;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------
    // predictor: register copy, loaded grid and the solved points in flight
    // ------------------------------------------------------------------
    logic [VAL_W-1:0]   gain_cfg      = GAIN_RST;
    logic [VAL_W-1:0]   coupling_cfg  = COUP_RST;
    logic [VAL_W-1:0]   inv_denom_cfg = INV_RST;
    logic [FLOOR_W-1:0] floor_cfg     = FLOOR_RST;
    logic [SWEEP_W-1:0] sweeps_cfg    = SWEEPS_RST;

    logic [VAL_W-1:0] field_pts [GRID_POINTS];
    logic [VAL_W-1:0] rhs_pts   [GRID_POINTS];
    int               loaded_points = 0;

    t_field_sample expected_field [$];

    // knobs shared between the test sequence and the channel drivers
    bit src_idle      = 1'b0;
    bit sink_idle     = 1'b0;
    int sink_hold_req = 0;
    int bad_results   = 0;
    int random_items  = 0;

    // saturate to 32 bits, then lift to the floor
    function automatic logic [VAL_W-1:0] lift_to_floor(input logic [63:0] v);
        logic [63:0] r;
        r = v;
        if (r > 64'hFFFF_FFFF) begin
            r = 64'hFFFF_FFFF;
        end
        if (r < {48'd0, floor_cfg}) begin
            r = {48'd0, floor_cfg};
        end
        return r[VAL_W-1:0];
    endfunction

    // gain on a signed q16.16 sample; anything negative lands on the floor
    function automatic logic [VAL_W-1:0] scaled_source(input logic [VAL_W-1:0] raw);
        logic [63:0] mag;
        if (raw[VAL_W-1]) begin
            return lift_to_floor(64'd0);
        end
        mag = {33'd0, raw[VAL_W-2:0]} * {32'd0, gain_cfg};
        return lift_to_floor(mag >> 16);
    endfunction

    // one three-point jacobi update, before relaxation
    function automatic logic [VAL_W-1:0] stencil_update(input logic [VAL_W-1:0] rhs,
                                                       input logic [VAL_W-1:0] left,
                                                       input logic [VAL_W-1:0] right);
        logic [63:0] c;
        logic [63:0] inv;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] num;
        logic [63:0] q;
        c    = {32'd0, coupling_cfg};
        inv  = {32'd0, inv_denom_cfg};
        sum  = {32'd0, left} + {32'd0, right};
        // coupling*(left+right) >> 16, split so nothing overflows 64 bits
        term = c * (sum >> 16) + ((c * (sum & 64'hFFFF)) >> 16);
        num  = {32'd0, rhs} + term;
        q    = (num >> 32) * inv + (((num & 64'hFFFF_FFFF) * inv) >> 32);
        return lift_to_floor(q);
    endfunction

    // run all sweeps on the loaded grid and queue the emitted points
    task automatic solve_field();
        logic [VAL_W-1:0] fresh [GRID_POINTS];
        logic [63:0]      mix;
        int               n;
        t_field_sample    pt;
        n = loaded_points;
        // no interior below five points: starting field goes out as is
        if (n >= 2 * GUARD_POINTS + 1) begin
            for (int s = 0; s < int'(sweeps_cfg); s++) begin
                for (int i = GUARD_POINTS; i + GUARD_POINTS < n; i++) begin
                    fresh[i] = stencil_update(rhs_pts[i], field_pts[i-1], field_pts[i+1]);
                end
                // relax by 0.8 toward the new value, division truncates
                for (int i = GUARD_POINTS; i + GUARD_POINTS < n; i++) begin
                    mix          = 64'd4 * {32'd0, fresh[i]} + {32'd0, field_pts[i]};
                    field_pts[i] = VAL_W'(mix / 64'd5);
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            pt.value = lift_to_floor({32'd0, field_pts[i]});
            pt.last  = (i == n - 1);
            expected_field.push_back(pt);
        end
        loaded_points = 0;
    endtask

    // one accepted source item; points past the grid size are dropped,
    // but a last flag on a dropped one still starts the solve
    task automatic load_source_point(input logic [VAL_W-1:0] raw, input logic last);
        logic [VAL_W-1:0] v;
        if (loaded_points < GRID_POINTS) begin
            v                        = scaled_source(raw);
            rhs_pts[loaded_points]   = v;
            field_pts[loaded_points] = v;
            loaded_points++;
        end
        if (last) begin
            solve_field();
        end
    endtask

    // ------------------------------------------------------------------
    // result side: random ready gaps, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial begin : drive_result_ready
        int gap;
        res_ch.ready = 1'b0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (sink_hold_req > 0) begin
                res_ch.ready = 1'b0;
                repeat (sink_hold_req) @(negedge clk);
                sink_hold_req = 0;
            end
            gap = sink_idle ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                res_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_ch.ready = 1'b1;
            // stay ready until an item goes out or a hold-off is asked for
            @(posedge clk);
            while (!res_ch.valid && sink_hold_req == 0) @(posedge clk);
        end
    end

    // compare each accepted result with the oldest queued point
    always @(posedge clk) begin : check_results
        t_field_sample want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_field.size() == 0) begin
                bad_results++;
                if (bad_results <= MAX_REPORTS) begin
                    $display("unexpected result item: value %h last %b",
                             res_ch.smoothed_value, res_ch.last_value);
                end
            end else begin
                want = expected_field.pop_front();
                if (res_ch.smoothed_value !== want.value || res_ch.last_value !== want.last) begin
                    bad_results++;
                    if (bad_results <= MAX_REPORTS) begin
                        $display("result mismatch: expected value %h last %b, got value %h last %b",
                                 want.value, want.last, res_ch.smoothed_value, res_ch.last_value);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // source side and register writes, all driven on the falling edge
    // ------------------------------------------------------------------
    task automatic send_point(input logic [VAL_W-1:0] raw, input logic last);
        int gap;
        gap = src_idle ? $urandom_range(0, 6) : 0;
        @(negedge clk);
        if (gap > 0) begin
            src_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        src_ch.valid        = 1'b1;
        src_ch.source_value = raw;
        src_ch.last_point   = last;
        @(posedge clk);
        while (!src_ch.ready) @(posedge clk);
        load_source_point(raw, last);
    endtask

    // drop valid, then wait for the block to empty out
    task automatic wait_for_results();
        @(negedge clk);
        src_ch.valid = 1'b0;
        while (expected_field.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        // register widths mask the written data
        case (idx)
            CFG_SOURCE_GAIN: gain_cfg      = data;
            CFG_COUPLING:    coupling_cfg  = data;
            CFG_INV_DENOM:   inv_denom_cfg = data;
            CFG_FLOOR:       floor_cfg     = data[FLOOR_W-1:0];
            CFG_SWEEPS:      sweeps_cfg    = data[SWEEP_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic apply_settings(input logic [VAL_W-1:0] gain, input logic [VAL_W-1:0] coup,
                                  input logic [VAL_W-1:0] inv, input logic [VAL_W-1:0] fl,
                                  input logic [VAL_W-1:0] sweeps);
        write_reg(CFG_SOURCE_GAIN, gain);
        write_reg(CFG_COUPLING, coup);
        write_reg(CFG_INV_DENOM, inv);
        write_reg(CFG_FLOOR, fl);
        write_reg(CFG_SWEEPS, sweeps);
    endtask

    // sample mix: full range, small positives that stay unsaturated,
    // small negatives and the corner values
    function automatic logic [VAL_W-1:0] random_source();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0004_0000);
            2: return -$urandom_range(1, 32'h0004_0000);
            default: begin
                case ($urandom_range(0, 4))
                    0: return 32'h0000_0000;
                    1: return 32'h0000_0001;
                    2: return 32'h7FFF_FFFF;
                    3: return 32'h8000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    // one well-formed grid, last flag on its final point
    task automatic send_grid(input int len);
        for (int i = 0; i < len; i++) begin
            send_point(random_source(), i == len - 1);
        end
        random_items += (len < GRID_POINTS) ? len : GRID_POINTS;
    endtask

    // mostly mid-sized grids, some short ones without interior, some
    // longer than the store so the tail is dropped
    function automatic int random_grid_len();
        case ($urandom_range(0, 11))
            0:       return $urandom_range(1, 4);
            9, 10:   return $urandom_range(21, GRID_POINTS);
            11:      return $urandom_range(GRID_POINTS + 1, GRID_POINTS + 6);
            default: return $urandom_range(5, 20);
        endcase
    endfunction

    task automatic randomize_settings();
        logic [VAL_W-1:0] gain;
        logic [VAL_W-1:0] coup;
        logic [VAL_W-1:0] inv;
        logic [63:0]      ratio;
        logic [FLOOR_W-1:0] fl;
        logic [SWEEP_W-1:0] sweeps;
        case ($urandom_range(0, 5))
            0:       gain = '0;
            1:       gain = '1;
            2:       gain = $urandom;
            default: gain = $urandom_range(0, 32'h0014_0000);
        endcase
        // mostly a matching coupling / reciprocal pair, sometimes unrelated
        case ($urandom_range(0, 5))
            0: begin
                coup = $urandom;
                inv  = $urandom;
            end
            1: begin
                coup = '1;
                inv  = $urandom_range(0, 3);
            end
            default: begin
                coup  = $urandom_range(0, 32'h0004_0000);
                ratio = (64'd1 << 48) / (64'd65536 + 64'd2 * coup);
                inv   = (ratio > 64'hFFFF_FFFF) ? '1 : ratio[VAL_W-1:0];
            end
        endcase
        case ($urandom_range(0, 4))
            0:       fl = '0;
            1:       fl = '1;
            2:       fl = $urandom;
            default: fl = $urandom_range(0, 255);
        endcase
        case ($urandom_range(0, 7))
            0:       sweeps = '0;
            1:       sweeps = $urandom_range(13, 100);
            default: sweeps = $urandom_range(1, 12);
        endcase
        // junk in the unused upper bits of the narrow registers
        apply_settings(gain, coup, inv, {16'($urandom), fl}, {22'($urandom), sweeps});
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values, extreme samples: max positive saturates, negatives floor
    task automatic test_default_settings();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        send_point(32'h0001_8000, 1'b0);
        send_point(32'h7FFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 1'b0);
        send_point(32'hFFFF_FFFF, 1'b0);
        send_point(32'h0000_0000, 1'b0);
        send_point(32'h0000_0001, 1'b1);
        wait_for_results();
    endtask

    // single point, four points with no interior, five with one
    task automatic test_short_grids();
        write_reg(CFG_SWEEPS, 32'd5);
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        send_point(32'h0002_0000, 1'b1);
        send_point(32'h0000_1000, 1'b0);
        send_point(32'h0003_0000, 1'b0);
        send_point(32'hFFFF_0000, 1'b0);
        send_point(32'h0000_0100, 1'b1);
        send_point(32'h0000_0001, 1'b0);
        send_point(32'h0000_2000, 1'b0);
        send_point(32'h0100_0000, 1'b0);
        send_point(32'h0000_2000, 1'b0);
        send_point(32'h0000_0001, 1'b1);
        wait_for_results();
    endtask

    // zero sweeps returns the clamped starting field
    task automatic test_zero_sweeps();
        write_reg(CFG_SWEEPS, 32'd0);
        src_idle  = 1'b1;
        sink_idle = 1'b0;
        send_grid(6);
        wait_for_results();
    endtask

    // all-zero registers but three sweeps, all-ones registers (1023 sweeps on a small grid),
    // then maximum coupling against a tiny reciprocal
    task automatic test_register_extremes();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        apply_settings('0, '0, '0, '0, 32'd3);
        send_grid(7);
        wait_for_results();
        apply_settings('1, '1, '1, '1, '1);
        send_grid(5);
        wait_for_results();
        apply_settings(GAIN_RST, '1, 32'd1, '0, 32'd7);
        send_grid(9);
        wait_for_results();
    endtask

    // result side blocked for a long stretch while grids keep coming,
    // so the block holds off its input
    task automatic test_output_backpressure();
        apply_settings(GAIN_RST, COUP_RST, INV_RST, 32'd1, 32'd4);
        src_idle      = 1'b0;
        sink_idle     = 1'b1;
        sink_hold_req = BLOCK_STALL;
        send_grid(6);
        send_grid(10);
        send_grid(3);
        wait_for_results();
    endtask

    // random settings per phase, a few grids each, sometimes a full drain
    // between grids
    task automatic test_random_grids();
        int grids;
        while (random_items < RANDOM_ITEMS) begin
            randomize_settings();
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            grids     = $urandom_range(1, 3);
            for (int g = 0; g < grids; g++) begin
                send_grid(random_grid_len());
                if ($urandom_range(0, 3) == 0) begin
                    wait_for_results();
                end
            end
            wait_for_results();
        end
    endtask

    initial begin : run_tests
        src_ch.valid        = 1'b0;
        src_ch.source_value = '0;
        src_ch.last_point   = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_settings();
        test_short_grids();
        test_zero_sweeps();
        test_register_extremes();
        test_output_backpressure();
        test_random_grids();

        wait_for_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (expected_field.size() != 0) begin
            bad_results++;
        end
        if (bad_results == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
